### hdl/lsde_pkg.sv
package lsde_pkg;

   // Number of axis trackers and field widths
   localparam int AXES       = 4;
   localparam int AXIS_W     = 2;
   localparam int INTERVAL_W = 24;
   localparam int THRESH_W   = 8;

   // Configuration port
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = INTERVAL_W;

   localparam logic [CSR_INDEX_W-1:0] CSR_SAMPLE_INTERVAL    = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_DEBOUNCE_THRESHOLD = 1'd1;

   localparam logic [INTERVAL_W-1:0] INTERVAL_RESET  = INTERVAL_W'(100000);
   localparam logic [THRESH_W-1:0]   THRESHOLD_RESET = THRESH_W'(10);

   // One tick word as seen by the axis trackers
   typedef struct packed {
      logic [AXIS_W-1:0] axis;
      logic              level;
      logic              take_rising;
      logic              take_falling;
      logic              clear_axis;
      logic              clear_all;
      logic              sample;
   } step_type;

   // Flags and level of the selected axis after the update
   typedef struct packed {
      logic rising;
      logic falling;
      logic level;
   } status_type;

endpackage

### hdl/lsde_tick.sv
module lsde_tick (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              advance,
   input  logic [lsde_pkg::INTERVAL_W-1:0]   interval,
   output logic                              sample
);
   import lsde_pkg::*;

   logic [INTERVAL_W-1:0] tick_ff;
   logic [INTERVAL_W-1:0] tick_in;
   logic [INTERVAL_W:0]   tick_inc;

   // Wrapping to zero at the interval and comparing reduces to one add and compare
   always_comb begin
      tick_inc = {1'b0, tick_ff} + (INTERVAL_W+1)'(1);
      sample   = tick_inc >= {1'b0, interval};
      tick_in  = sample ? '0 : tick_inc[INTERVAL_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_ff <= '0;
      end else if (advance) begin
         tick_ff <= tick_in;
      end
   end

endmodule

### hdl/lsde_axes.sv
module lsde_axes (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            advance,
   input  lsde_pkg::step_type              step,
   input  logic [lsde_pkg::THRESH_W-1:0]   threshold,
   output lsde_pkg::status_type            status
);
   import lsde_pkg::*;

   logic [AXES-1:0]     lev_ff, rise_ff, fall_ff;
   logic [THRESH_W-1:0] cnt_ff [AXES];

   logic [AXES-1:0]     lev_in, rise_in, fall_in;
   logic [THRESH_W-1:0] cnt_in [AXES];
   logic [AXES-1:0]     sel_v, rise_mid, fall_mid;

   always_comb begin
      logic                clr;
      logic                l0, r0, f0;
      logic [THRESH_W-1:0] c0;
      logic [THRESH_W:0]   c_inc;
      for (int a = 0; a < AXES; a++) begin
         sel_v[a] = int'(step.axis) == a;
         clr      = step.clear_all || (step.clear_axis && sel_v[a]);
         l0       = clr ? 1'b0 : lev_ff[a];
         r0       = clr ? 1'b0 : rise_ff[a];
         f0       = clr ? 1'b0 : fall_ff[a];
         c0       = clr ? '0 : cnt_ff[a];
         c_inc    = {1'b0, c0} + (THRESH_W+1)'(1);

         lev_in[a]   = l0;
         rise_mid[a] = r0;
         fall_mid[a] = f0;
         cnt_in[a]   = c0;
         if (step.sample && sel_v[a]) begin
            if (step.level != l0) begin
               // threshold of zero behaves as one: c_inc is never below it
               if (c_inc >= {1'b0, threshold}) begin
                  cnt_in[a] = '0;
                  lev_in[a] = step.level;
                  if (step.level) begin
                     rise_mid[a] = 1'b1;
                  end else begin
                     fall_mid[a] = 1'b1;
                  end
               end else begin
                  cnt_in[a] = c_inc[THRESH_W-1:0];
               end
            end else begin
               cnt_in[a] = '0;
            end
         end

         // consume after reporting
         rise_in[a] = rise_mid[a] && !(sel_v[a] && step.take_rising);
         fall_in[a] = fall_mid[a] && !(sel_v[a] && step.take_falling);
      end
   end

   // out-of-range axis selects nothing and reads as zero
   assign status.rising  = |(sel_v & rise_mid);
   assign status.falling = |(sel_v & fall_mid);
   assign status.level   = |(sel_v & lev_in);

   always_ff @(posedge clock) begin
      if (reset) begin
         lev_ff  <= '0;
         rise_ff <= '0;
         fall_ff <= '0;
         for (int a = 0; a < AXES; a++) begin
            cnt_ff[a] <= '0;
         end
      end else if (advance) begin
         lev_ff  <= lev_in;
         rise_ff <= rise_in;
         fall_ff <= fall_in;
         for (int a = 0; a < AXES; a++) begin
            cnt_ff[a] <= cnt_in[a];
         end
      end
   end

endmodule

### hdl/limit_switch_debounce_edges_top.sv
// Limit switch debouncer with sticky edge flags, one tracker per axis.
// Request channel (req_*): one word per timer tick, carrying the selected
// axis, its raw limit level, flag consume strobes and clear strobes.
// Response channel (rsp_*): one word per request word, giving the selected
// axis's rising/falling flags after this tick's update, its debounced level
// and whether the tick was a sampling tick.
// CSR port: sample_interval (index 0) and debounce_threshold (index 1), written
// on any cycle with csr_write_enable high; change them only while idle.
// Path: a word accepted into the input register goes through one pass of update logic
// into the response register, which drives the rsp_* outputs.
// Throughput: one word per clock while the receiver is not stalling; the single update pass
// of the tick counter and the axis trackers sets that figure.
// Reset (synchronous, active high) clears every tracker and the tick counter
// and loads the default interval and threshold.
// A stalled receiver holds the response register; the input register then
// takes one more word and req_ready falls until the response is taken.
module limit_switch_debounce_edges_top (
   input  logic                                clock,
   input  logic                                reset,

   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [lsde_pkg::AXIS_W-1:0]         req_axis,
   input  logic                                req_limit_level,
   input  logic                                req_take_rising,
   input  logic                                req_take_falling,
   input  logic                                req_clear_axis_state,
   input  logic                                req_clear_all_axes,

   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic                                rsp_rising_edge,
   output logic                                rsp_falling_edge,
   output logic                                rsp_stable_level,
   output logic                                rsp_sample_taken,

   input  logic                                csr_write_enable,
   input  logic [lsde_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [lsde_pkg::CSR_DATA_W-1:0]     csr_write_data
);
   import lsde_pkg::*;

   // configuration registers
   logic [INTERVAL_W-1:0] interval_ff;
   logic [THRESH_W-1:0]   threshold_ff;

   // input register
   logic                  in_valid_ff, in_valid_in;
   step_type              in_word_ff;

   // response register
   logic                  out_valid_ff, out_valid_in;
   status_type            out_status_ff;
   logic                  out_sample_ff;

   logic                  advance;
   logic                  req_fire;
   logic                  sample;
   step_type              step;
   status_type            status;

   // the pass fires when the response register is free or being emptied
   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign req_fire  = req_valid && req_ready;

   assign in_valid_in  = req_fire || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         interval_ff  <= INTERVAL_RESET;
         threshold_ff <= THRESHOLD_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_SAMPLE_INTERVAL: begin
               interval_ff <= csr_write_data;
            end
            CSR_DEBOUNCE_THRESHOLD: begin
               threshold_ff <= csr_write_data[THRESH_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_word_ff.axis         <= req_axis;
         in_word_ff.level        <= req_limit_level;
         in_word_ff.take_rising  <= req_take_rising;
         in_word_ff.take_falling <= req_take_falling;
         in_word_ff.clear_axis   <= req_clear_axis_state;
         in_word_ff.clear_all    <= req_clear_all_axes;
         in_word_ff.sample       <= 1'b0;
      end
      if (advance) begin
         out_status_ff <= status;
         out_sample_ff <= sample;
      end
   end

   // sample decision joins the registered word
   always_comb begin
      step        = in_word_ff;
      step.sample = sample;
   end

   lsde_tick u_tick (
      .clock    (clock),
      .reset    (reset),
      .advance  (advance),
      .interval (interval_ff),
      .sample   (sample)
   );

   lsde_axes u_axes (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .step      (step),
      .threshold (threshold_ff),
      .status    (status)
   );

   assign rsp_valid        = out_valid_ff;
   assign rsp_rising_edge  = out_status_ff.rising;
   assign rsp_falling_edge = out_status_ff.falling;
   assign rsp_stable_level = out_status_ff.level;
   assign rsp_sample_taken = out_sample_ff;

`ifndef SYNTHESIS
   // a held word with a stalled response must block the request side
   assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && out_valid_ff && !rsp_ready) |-> !req_ready)
      else $error("request taken while both stages are blocked");

   // clear-all without a sample leaves nothing set on any axis
   assert property (@(posedge clock) disable iff (reset)
      (advance && in_word_ff.clear_all && !sample) |=>
      (!rsp_rising_edge && !rsp_falling_edge && !rsp_stable_level))
      else $error("tracker state survived clear-all");

   // an interval of one samples on every tick
   assert property (@(posedge clock) disable iff (reset)
      (advance && interval_ff == INTERVAL_W'(1)) |=> rsp_sample_taken)
      else $error("tick skipped with interval of one");
`endif

endmodule
